// ===== hdl/bqpf_pkg.sv =====
// ----------------------------------------------------------------------------
// bqpf_pkg: shared types, constants and saturating helpers
// Carries the per-request context record and the Q32.32 arithmetic helpers
// used by the rotating bar quadrupole force pipeline.
// ----------------------------------------------------------------------------
package bqpf_pkg;

	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;

	localparam logic signed [63:0] ONE_Q32  = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;

	typedef enum logic [2:0] {
		REG_SOFT_MODE,
		REG_FORCE_SCALE,
		REG_SCALE_LENGTH,
		REG_COS_TWO_PHI,
		REG_SIN_TWO_PHI,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_CENTER_Z
	} cfg_reg_t;

	// Context that travels with one request down the pipeline
	typedef struct packed {
		logic               vld;
		logic [31:0]        idx;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [63:0] xy;
		logic signed [63:0] dsq;
		logic [31:0]        r;
		logic               le;
		logic               rz;
		logic               dz;
		logic signed [63:0] pp;
		logic signed [63:0] lin_x;
		logic signed [63:0] lin_y;
		logic signed [63:0] ppr;
		logic signed [63:0] t;
		logic signed [63:0] rat_x;
		logic signed [63:0] rat_y;
		logic signed [63:0] rat_z;
		logic signed [63:0] p;
		logic signed [63:0] wt;
	} ctx_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		mag64 = a[63] ? (~a + 64'd1) : a;
	endfunction

	function automatic logic signed [63:0] with_sign(input logic [63:0] mag, input logic neg);
		logic [63:0] m;
		m = mag;
		if (neg) begin
			if (m > 64'h8000_0000_0000_0000) m = 64'h8000_0000_0000_0000;
			with_sign = signed'(~m + 64'd1);
		end else begin
			if (m[63]) m = 64'h7FFF_FFFF_FFFF_FFFF;
			with_sign = signed'(m);
		end
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) sat_add = s[64] ? S64_MIN : S64_MAX;
		else sat_add = s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) sat_sub = s[64] ? S64_MIN : S64_MAX;
		else sat_sub = s[63:0];
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) clamp32 = 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648) clamp32 = 32'sh8000_0000;
		else clamp32 = v[31:0];
	endfunction

	// Saturating multiply by a small positive integer
	function automatic logic signed [63:0] mul_small(input logic signed [63:0] v,
		input logic [2:0] k);
		logic [66:0] prod;
		logic [63:0] res;
		prod = 67'(mag64(v)) * 67'(k);
		res = (prod[66:64] != 3'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
		mul_small = with_sign(res, v[63]);
	endfunction

endpackage

// ===== hdl/bqpf_mul.sv =====
// ----------------------------------------------------------------------------
// bqpf_mul: pipelined 64x64 saturating fixed point multiply
// Sign and magnitude, four 32x32 partial products, then combine, shift right,
// truncate toward zero and saturate, registered in stages s1, s2 and s3.
// ----------------------------------------------------------------------------
module bqpf_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic signed [63:0]    a,
	input  logic signed [63:0]    b,
	input  logic [5:0]            sh,
	input  bqpf_pkg::ctx_t        tag_in,
	output logic signed [63:0]    p,
	output bqpf_pkg::ctx_t        tag_out
);
	import bqpf_pkg::*;

	logic [63:0]  ua_s1, ub_s1;
	logic         neg_s1, neg_s2;
	ctx_t         tag_s1, tag_s2, tag_s3;
	logic [63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic signed [63:0] p_s3;
	logic [127:0] full, shifted;
	logic [63:0]  res;

	always_comb begin
		full = {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
			+ {p11_s2, 64'd0};
		shifted = full >> sh;
		res = (shifted[127:64] != 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1  <= mag64(a);
			ub_s1  <= mag64(b);
			neg_s1 <= a[63] ^ b[63];
			p00_s2 <= ua_s1[31:0] * ub_s1[31:0];
			p01_s2 <= ua_s1[31:0] * ub_s1[63:32];
			p10_s2 <= ua_s1[63:32] * ub_s1[31:0];
			p11_s2 <= ua_s1[63:32] * ub_s1[63:32];
			neg_s2 <= neg_s1;
			p_s3   <= with_sign(res, neg_s2);
		end
	end

	assign p       = p_s3;
	assign tag_out = tag_s3;

endmodule

// ===== hdl/bqpf_div.sv =====
// ----------------------------------------------------------------------------
// bqpf_div: pipelined restoring divider, (|a| << sh) / d, sh or d of 0 read as 1
// One quotient bit per stage over 64 stages, a setup stage in front and a
// sign and saturation stage behind.
// ----------------------------------------------------------------------------
module bqpf_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic signed [63:0]    a,
	input  logic [63:0]           d,
	input  logic [5:0]            sh,
	input  bqpf_pkg::ctx_t        tag_in,
	output logic signed [63:0]    q,
	output bqpf_pkg::ctx_t        tag_out
);
	import bqpf_pkg::*;

	logic [63:0] ua, d0;
	logic [6:0]  s7;
	logic [63:0] hi, lo;

	logic [63:0] hi_s1, lo_s1, d_s1;
	logic        ovf_s1, neg_s1;
	ctx_t        tag_s1;

	logic [63:0] rem_s [DIV_STEPS];
	logic [63:0] low_s [DIV_STEPS];
	logic [63:0] quo_s [DIV_STEPS];
	logic [63:0] dvs_s [DIV_STEPS];
	logic        ovf_s [DIV_STEPS];
	logic        neg_s [DIV_STEPS];
	ctx_t        tag_s [DIV_STEPS];

	logic signed [63:0] q_sf;
	ctx_t               tag_sf;

	always_comb begin
		ua = mag64(a);
		d0 = (d == 64'd0) ? 64'd1 : d;
		s7 = (sh == 6'd0) ? 7'd1 : {1'b0, sh};
		hi = ua >> (7'd64 - s7);
		lo = ua << s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_s1 <= '0;
		else if (en) tag_s1 <= tag_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1  <= hi;
			lo_s1  <= lo;
			d_s1   <= d0;
			ovf_s1 <= hi >= d0;
			neg_s1 <= a[63];
		end
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [63:0] r_in, lo_in, q_in, d_in, r_sh, r_nx, q_nx;
		logic        ovf_in, neg_in, take;
		ctx_t        t_in;

		if (i == 0) begin : g_first
			assign r_in   = hi_s1;
			assign lo_in  = lo_s1;
			assign q_in   = 64'd0;
			assign d_in   = d_s1;
			assign ovf_in = ovf_s1;
			assign neg_in = neg_s1;
			assign t_in   = tag_s1;
		end else begin : g_next
			assign r_in   = rem_s[i-1];
			assign lo_in  = low_s[i-1];
			assign q_in   = quo_s[i-1];
			assign d_in   = dvs_s[i-1];
			assign ovf_in = ovf_s[i-1];
			assign neg_in = neg_s[i-1];
			assign t_in   = tag_s[i-1];
		end

		always_comb begin
			r_sh = {r_in[62:0], lo_in[63]};
			take = r_in[63] || (r_sh >= d_in);
			r_nx = take ? (r_sh - d_in) : r_sh;
			q_nx = {q_in[62:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tag_s[i] <= '0;
			else if (en) tag_s[i] <= t_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= r_nx;
				low_s[i] <= {lo_in[62:0], 1'b0};
				quo_s[i] <= q_nx;
				dvs_s[i] <= d_in;
				ovf_s[i] <= ovf_in;
				neg_s[i] <= neg_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_sf <= '0;
		else if (en) tag_sf <= tag_s[DIV_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_sf <= ovf_s[DIV_STEPS-1] ? with_sign(64'hFFFF_FFFF_FFFF_FFFF, neg_s[DIV_STEPS-1])
				: with_sign(quo_s[DIV_STEPS-1], neg_s[DIV_STEPS-1]);
		end
	end

	assign q       = q_sf;
	assign tag_out = tag_sf;

endmodule

// ===== hdl/bqpf_sqrt.sv =====
// ----------------------------------------------------------------------------
// bqpf_sqrt: pipelined floor square root of a 64-bit value
// One result bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module bqpf_sqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [63:0]           n,
	input  bqpf_pkg::ctx_t        tag_in,
	output logic [31:0]           root,
	output bqpf_pkg::ctx_t        tag_out
);
	import bqpf_pkg::*;

	logic [63:0] rem_s [SQRT_STEPS];
	logic [63:0] res_s [SQRT_STEPS];
	ctx_t        tag_s [SQRT_STEPS];

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] rem_in, res_in, trial, rem_nx, res_nx;
		ctx_t        t_in;

		if (i == 0) begin : g_first
			assign rem_in = n;
			assign res_in = 64'd0;
			assign t_in   = tag_in;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign res_in = res_s[i-1];
			assign t_in   = tag_s[i-1];
		end

		always_comb begin
			trial = res_in + BIT;
			if (rem_in >= trial) begin
				rem_nx = rem_in - trial;
				res_nx = (res_in >> 1) + BIT;
			end else begin
				rem_nx = rem_in;
				res_nx = res_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tag_s[i] <= '0;
			else if (en) tag_s[i] <= t_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= rem_nx;
				res_s[i] <= res_nx;
			end
		end
	end

	assign root    = res_s[SQRT_STEPS-1][31:0];
	assign tag_out = tag_s[SQRT_STEPS-1];

endmodule

// ===== hdl/bar_quadrupole_particle_force_top.sv =====
// ----------------------------------------------------------------------------
// bar_quadrupole_particle_force_top: rotating bar quadrupole force kernel
// Subtracts the center, evaluates the bar pattern, radius and radial profile
// and returns the saturated acceleration and potential increments.
//
//   channel  | dir | handshake               | payload
//   s_axis   | in  | s_axis_tvalid/tready    | tdata: index, pos_x/y/z; tuser: level_ok
//   m_axis   | out | m_axis_tvalid/tready    | tdata: index, accel_x/y/z, potential
//   cfg      | in  | cfg_we                  | cfg_idx, cfg_wdata
//
// One request enters per cycle unless the pipeline holds; its depth is set by
// the 32-stage root and the two 66-stage dividers in series, among others.
// Requests with level_ok clear travel as bubbles and give no result.
// All stages advance together; when the output register is full and not
// taken, the whole pipeline holds. Reset clears every stage valid bit and
// loads the register defaults.
// ----------------------------------------------------------------------------
module bar_quadrupole_particle_force_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // particle_index, pos_x, pos_y, pos_z
	input  logic         s_axis_tuser,   // level_ok
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata,   // out_index, accel_x, accel_y, accel_z, potential
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [31:0]  cfg_wdata
);
	import bqpf_pkg::*;

	// configuration
	logic               soft_q;
	logic signed [31:0] amp_q, cos_q, sin_q, cx_q, cy_q, cz_q;
	logic [30:0]        b_q, b_eff;

	logic en;

	logic signed [31:0] px, py, pz;
	logic signed [32:0] dx, dy, dz;

	ctx_t c1_s1, c2_s2, c3_s3, c_sq, c4, c5m, c5_s5, c6d, c6, c7, c8, c9;
	ctx_t c10_s10, c11, c12_s12, c13, c14, c15, c16_s16, c17_s17, c18;
	ctx_t c1_d, c2_d, c3_d, c5_d, c10_d, c12_d;

	logic signed [63:0] xx_s2, yy_s2, zz_s2;
	logic [63:0]        n_s3;
	logic [31:0]        r_sq;

	logic signed [63:0] pa, pb, lxa, lxb, lya, lyb;
	logic signed [63:0] tn_s5, tn;
	logic [63:0]        td_s5, den_s5, td, den, bsum;

	logic signed [63:0] ppr_q, t_q, rx_q, ry_q, rz_q;
	logic signed [63:0] t2, t4, p_raw;
	logic [63:0]        dw_s10;
	logic signed [63:0] wq, w_s12, omw_s12, m_raw, m_sel, k;
	logic signed [63:0] kx, ky, kz, lx, ly, pw;
	logic signed [63:0] t2x_s16, t1x_s16, t2y_s16, t1y_s16, t2z_s16, pw_s16;
	logic signed [63:0] ax_s17, ay_s17, az_s17, pw_s17;
	logic signed [63:0] ox, oy, oz, opot;

	logic               m_tvalid_q;
	logic [159:0]       m_tdata_q;

	assign en            = !m_tvalid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign b_eff         = (b_q == 31'd0) ? 31'd1 : b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_q <= 1'b0;
			amp_q  <= '0;
			b_q    <= 31'd65536;
			cos_q  <= 32'sh4000_0000;
			sin_q  <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
			cz_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SOFT_MODE:    soft_q <= cfg_wdata[0];
				REG_FORCE_SCALE:  amp_q  <= signed'(cfg_wdata);
				REG_SCALE_LENGTH: b_q    <= cfg_wdata[30:0];
				REG_COS_TWO_PHI:  cos_q  <= signed'(cfg_wdata);
				REG_SIN_TWO_PHI:  sin_q  <= signed'(cfg_wdata);
				REG_CENTER_X:     cx_q   <= signed'(cfg_wdata);
				REG_CENTER_Y:     cy_q   <= signed'(cfg_wdata);
				REG_CENTER_Z:     cz_q   <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// stage 1: relative coordinates
	always_comb begin
		px = signed'(s_axis_tdata[63:32]);
		py = signed'(s_axis_tdata[95:64]);
		pz = signed'(s_axis_tdata[127:96]);
		dx = {px[31], px} - {cx_q[31], cx_q};
		dy = {py[31], py} - {cy_q[31], cy_q};
		dz = {pz[31], pz} - {cz_q[31], cz_q};
		c1_d     = '0;
		c1_d.vld = s_axis_tvalid && s_axis_tuser;
		c1_d.idx = s_axis_tdata[31:0];
		c1_d.x   = clamp32(64'(dx));
		c1_d.y   = clamp32(64'(dy));
		c1_d.z   = clamp32(64'(dz));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_s1 <= '0;
		end else if (en) begin
			c1_s1 <= c1_d;
		end
	end

	// stage 2: squares and cross product
	always_comb begin
		c2_d    = c1_s1;
		c2_d.xy = c1_s1.x * c1_s1.y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c2_s2 <= '0;
		end else if (en) begin
			c2_s2 <= c2_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2 <= c1_s1.x * c1_s1.x;
			yy_s2 <= c1_s1.y * c1_s1.y;
			zz_s2 <= c1_s1.z * c1_s1.z;
		end
	end

	// stage 3: radius squared and x^2 - y^2
	always_comb begin
		c3_d     = c2_s2;
		c3_d.dsq = xx_s2 - yy_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c3_s3 <= '0;
		end else if (en) begin
			c3_s3 <= c3_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) n_s3 <= unsigned'(xx_s2) + unsigned'(yy_s2) + unsigned'(zz_s2);
	end

	bqpf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.n(n_s3), .tag_in(c3_s3), .root(r_sq), .tag_out(c_sq)
	);

	always_comb begin
		c4    = c_sq;
		c4.r  = r_sq;
		c4.le = r_sq <= {1'b0, b_eff};
		c4.rz = r_sq == 32'd0;
		c4.dz = !soft_q && (r_sq == 32'd0);
	end

	// angular pattern and linear terms
	bqpf_mul u_mul_pa (.clk(clk), .arst_n(arst_n), .en(en), .a(c4.dsq), .b(64'(cos_q)),
		.sh(6'd30), .tag_in(c4), .p(pa), .tag_out(c5m));
	bqpf_mul u_mul_pb (.clk(clk), .arst_n(arst_n), .en(en), .a(c4.xy), .b(64'(sin_q)),
		.sh(6'd29), .tag_in(c4), .p(pb), .tag_out());
	bqpf_mul u_mul_lxa (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(c4.x)), .b(64'(cos_q)),
		.sh(6'd14), .tag_in(c4), .p(lxa), .tag_out());
	bqpf_mul u_mul_lxb (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(c4.y)), .b(64'(sin_q)),
		.sh(6'd14), .tag_in(c4), .p(lxb), .tag_out());
	bqpf_mul u_mul_lya (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(c4.x)), .b(64'(sin_q)),
		.sh(6'd14), .tag_in(c4), .p(lya), .tag_out());
	bqpf_mul u_mul_lyb (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(c4.y)), .b(64'(cos_q)),
		.sh(6'd14), .tag_in(c4), .p(lyb), .tag_out());

	// stage 5: combine pattern, pick divider operands
	always_comb begin
		bsum = {32'd0, c5m.r} + {33'd0, b_eff};
		if (soft_q) begin
			tn  = signed'({33'd0, b_eff});
			td  = bsum;
			den = bsum;
		end else if (c5m.le) begin
			tn  = signed'({32'd0, c5m.r});
			td  = {33'd0, b_eff};
			den = {32'd0, c5m.r};
		end else begin
			tn  = signed'({33'd0, b_eff});
			td  = {32'd0, c5m.r};
			den = {32'd0, c5m.r};
		end
		c5_d       = c5m;
		c5_d.pp    = sat_add(pa, pb);
		c5_d.lin_x = sat_add(lxa, lxb);
		c5_d.lin_y = sat_sub(lya, lyb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c5_s5 <= '0;
		end else if (en) begin
			c5_s5 <= c5_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tn_s5  <= tn;
			td_s5  <= td;
			den_s5 <= den;
		end
	end

	bqpf_div u_div_t (.clk(clk), .arst_n(arst_n), .en(en), .a(tn_s5), .d(td_s5),
		.sh(6'd32), .tag_in(c5_s5), .q(t_q), .tag_out(c6d));
	bqpf_div u_div_ppr (.clk(clk), .arst_n(arst_n), .en(en), .a(c5_s5.pp),
		.d({32'd0, c5_s5.r}), .sh(6'd16), .tag_in(c5_s5), .q(ppr_q), .tag_out());
	bqpf_div u_div_rx (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(c5_s5.x)), .d(den_s5),
		.sh(6'd32), .tag_in(c5_s5), .q(rx_q), .tag_out());
	bqpf_div u_div_ry (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(c5_s5.y)), .d(den_s5),
		.sh(6'd32), .tag_in(c5_s5), .q(ry_q), .tag_out());
	bqpf_div u_div_rz (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(c5_s5.z)), .d(den_s5),
		.sh(6'd32), .tag_in(c5_s5), .q(rz_q), .tag_out());

	// zero radius drops pp/r, and the coordinate ratios too unless soft mode is on
	always_comb begin
		c6       = c6d;
		c6.t     = t_q;
		c6.ppr   = c6d.rz ? 64'sd0 : ppr_q;
		c6.rat_x = c6d.dz ? 64'sd0 : rx_q;
		c6.rat_y = c6d.dz ? 64'sd0 : ry_q;
		c6.rat_z = c6d.dz ? 64'sd0 : rz_q;
	end

	// fifth power
	bqpf_mul u_mul_t2 (.clk(clk), .arst_n(arst_n), .en(en), .a(c6.t), .b(c6.t),
		.sh(6'd32), .tag_in(c6), .p(t2), .tag_out(c7));
	bqpf_mul u_mul_t4 (.clk(clk), .arst_n(arst_n), .en(en), .a(t2), .b(t2),
		.sh(6'd32), .tag_in(c7), .p(t4), .tag_out(c8));
	bqpf_mul u_mul_t5 (.clk(clk), .arst_n(arst_n), .en(en), .a(t4), .b(c8.t),
		.sh(6'd32), .tag_in(c8), .p(p_raw), .tag_out(c9));

	always_comb begin
		c10_d   = c9;
		c10_d.p = p_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c10_s10 <= '0;
		end else if (en) begin
			c10_s10 <= c10_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) dw_s10 <= unsigned'(ONE_Q32 + p_raw);
	end

	bqpf_div u_div_w (.clk(clk), .arst_n(arst_n), .en(en), .a(c10_s10.p), .d(dw_s10),
		.sh(6'd32), .tag_in(c10_s10), .q(wq), .tag_out(c11));

	// stage 12: w and 1-w by branch, weight by profile
	always_comb begin
		c12_d    = c11;
		c12_d.wt = soft_q ? c11.p : (c11.le ? (ONE_Q32 - wq) : wq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c12_s12 <= '0;
		end else if (en) begin
			c12_s12 <= c12_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s12   <= c11.le ? wq : (ONE_Q32 - wq);
			omw_s12 <= c11.le ? (ONE_Q32 - wq) : wq;
		end
	end

	bqpf_mul u_mul_m (.clk(clk), .arst_n(arst_n), .en(en), .a(w_s12), .b(omw_s12),
		.sh(6'd32), .tag_in(c12_s12), .p(m_raw), .tag_out(c13));

	assign m_sel = soft_q ? c13.p : m_raw;

	bqpf_mul u_mul_k (.clk(clk), .arst_n(arst_n), .en(en), .a(c13.ppr), .b(m_sel),
		.sh(6'd32), .tag_in(c13), .p(k), .tag_out(c14));

	// per-axis products
	bqpf_mul u_mul_kx (.clk(clk), .arst_n(arst_n), .en(en), .a(k), .b(c14.rat_x),
		.sh(6'd32), .tag_in(c14), .p(kx), .tag_out(c15));
	bqpf_mul u_mul_ky (.clk(clk), .arst_n(arst_n), .en(en), .a(k), .b(c14.rat_y),
		.sh(6'd32), .tag_in(c14), .p(ky), .tag_out());
	bqpf_mul u_mul_kz (.clk(clk), .arst_n(arst_n), .en(en), .a(k), .b(c14.rat_z),
		.sh(6'd32), .tag_in(c14), .p(kz), .tag_out());
	bqpf_mul u_mul_lx (.clk(clk), .arst_n(arst_n), .en(en), .a(c14.lin_x), .b(c14.wt),
		.sh(6'd32), .tag_in(c14), .p(lx), .tag_out());
	bqpf_mul u_mul_ly (.clk(clk), .arst_n(arst_n), .en(en), .a(c14.lin_y), .b(c14.wt),
		.sh(6'd32), .tag_in(c14), .p(ly), .tag_out());
	bqpf_mul u_mul_pw (.clk(clk), .arst_n(arst_n), .en(en), .a(c14.pp), .b(c14.wt),
		.sh(6'd32), .tag_in(c14), .p(pw), .tag_out());

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c16_s16 <= '0;
			c17_s17 <= '0;
		end else if (en) begin
			c16_s16 <= c15;
			c17_s17 <= c16_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t2x_s16 <= mul_small(kx, 3'd5);
			t2y_s16 <= mul_small(ky, 3'd5);
			t2z_s16 <= mul_small(kz, 3'd5);
			t1x_s16 <= mul_small(lx, 3'd2);
			t1y_s16 <= mul_small(ly, 3'd2);
			pw_s16  <= pw;
			ax_s17  <= sat_sub(t2x_s16, t1x_s16);
			ay_s17  <= sat_sub(t2y_s16, t1y_s16);
			az_s17  <= t2z_s16;
			pw_s17  <= pw_s16;
		end
	end

	// amplitude scaling
	bqpf_mul u_mul_ox (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(amp_q)), .b(ax_s17),
		.sh(6'd32), .tag_in(c17_s17), .p(ox), .tag_out(c18));
	bqpf_mul u_mul_oy (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(amp_q)), .b(ay_s17),
		.sh(6'd32), .tag_in(c17_s17), .p(oy), .tag_out());
	bqpf_mul u_mul_oz (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(amp_q)), .b(az_s17),
		.sh(6'd32), .tag_in(c17_s17), .p(oz), .tag_out());
	bqpf_mul u_mul_op (.clk(clk), .arst_n(arst_n), .en(en), .a(64'(amp_q)), .b(pw_s17),
		.sh(6'd32), .tag_in(c17_s17), .p(opot), .tag_out());

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid_q <= 1'b0;
		else if (en) m_tvalid_q <= c18.vld;
	end

	always_ff @(posedge clk) begin
		if (en) m_tdata_q <= {clamp32(opot), clamp32(oz), clamp32(oy), clamp32(ox), c18.idx};
	end

endmodule

// ===== tb/sv/bar_quadrupole_particle_force_top_test.sv =====
// ----------------------------------------------------------------------------
// bar_quadrupole_particle_force_top_test: self-checking bench for the bar force kernel
// Streams particle requests through the kernel under several register settings.
// Each request with level_ok set is predicted in Q32.32 fixed point and its whole
// force record compared with the returned one, with random stalls on both streams.
// ----------------------------------------------------------------------------
module bar_quadrupole_particle_force_top_test;
	import bqpf_pkg::*;

	localparam int LATENCY   = 197;
	localparam int WDOG_MAX  = 4000;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [31:0]        idx;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] pot;
	} force_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [159:0] m_axis_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_idx = 3'd0;
	logic [31:0]  cfg_wdata = '0;

	// register copy used for prediction
	logic               soft_on;
	logic signed [31:0] amp;
	logic [30:0]        b_len;
	logic signed [31:0] cos2, sin2, cen_x, cen_y, cen_z;

	force_t force_q[$];
	int     mismatches = 0;
	int     results_seen = 0;
	int     requests_sent = 0;
	int     idle_cycles = 0;
	bit     quiet = 1'b0;
	bit     hold_req = 1'b0;
	int     stall_left = 0;

	bar_quadrupole_particle_force_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- fixed-point predictor ----------------
	function automatic logic [63:0] abs64(input logic signed [63:0] a);
		return a[63] ? 64'(-a) : a;
	endfunction

	function automatic logic signed [63:0] signed_sat(input logic [63:0] m, input logic neg);
		if (neg) begin
			if (m >= 64'h8000_0000_0000_0000) return S64_MIN;
			return -$signed(m);
		end
		if (m[63]) return S64_MAX;
		return $signed(m);
	endfunction

	function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
		input logic signed [63:0] b, input int sh);
		logic [127:0] p;
		p = ({64'd0, abs64(a)} * {64'd0, abs64(b)}) >> sh;
		return signed_sat(p[127:64] != 0 ? '1 : p[63:0], a[63] ^ b[63]);
	endfunction

	function automatic logic signed [63:0] q_div(input logic signed [63:0] a,
		input logic [63:0] d, input int sh);
		logic [127:0] q;
		if (d == 0) d = 64'd1;
		q = ({64'd0, abs64(a)} << sh) / {64'd0, d};
		return signed_sat(q[127:64] != 0 ? '1 : q[63:0], a[63]);
	endfunction

	function automatic logic signed [63:0] s_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		return s > 65'(S64_MAX) ? S64_MAX : s < 65'(S64_MIN) ? S64_MIN : s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else res >>= 1;
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [63:0] fifth_power(input logic signed [63:0] t);
		logic signed [63:0] t2, t4;
		t2 = q_mul(t, t, 32);
		t4 = q_mul(t2, t2, 32);
		return q_mul(t4, t, 32);
	endfunction

	function automatic logic signed [31:0] axis_accel(input logic signed [63:0] k,
		input logic signed [63:0] coord, input logic [63:0] den,
		input logic signed [63:0] lin, input logic signed [63:0] wt);
		logic signed [63:0] ratio, t1, t2;
		ratio = den != 0 ? q_div(coord, den, 32) : 64'sd0;
		t2 = q_mul(q_mul(k, ratio, 32), 5, 0);
		t1 = q_mul(q_mul(lin, wt, 32), 2, 0);
		return sat32(q_mul(amp, s_add(t2, -$signed(65'(t1)) > 65'(S64_MAX) ?
			S64_MAX : -t1), 32));
	endfunction

	function automatic logic signed [31:0] rel(input logic signed [31:0] p,
		input logic signed [31:0] c);
		return sat32(64'(p) - 64'(c));
	endfunction

	function automatic force_t bar_force(input logic [31:0] id,
		input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [31:0] pz);
		logic signed [63:0] x, y, z, xx, yy, zz, xy, pp, lin_x, lin_y, ppr, wt, m, k;
		logic signed [63:0] w, omw, p;
		logic [63:0] r, den, b;
		force_t f;
		b = b_len != 0 ? 64'(b_len) : 64'd1;
		x = rel(px, cen_x);
		y = rel(py, cen_y);
		z = rel(pz, cen_z);
		xx = x * x;
		yy = y * y;
		zz = z * z;
		xy = x * y;
		pp = s_add(q_mul(xx - yy, cos2, 30), q_mul(xy, sin2, 29));
		lin_x = s_add(q_mul(x, cos2, 14), q_mul(y, sin2, 14));
		p = q_mul(y, cos2, 14);
		lin_y = s_add(q_mul(x, sin2, 14), p == S64_MIN ? S64_MAX : -p);
		r = floor_root(xx + yy + zz);
		ppr = r != 0 ? q_div(pp, r, 16) : 64'sd0;
		if (soft_on) begin
			den = b + r;
			wt = fifth_power(q_div(b, den, 32));
			m = wt;
		end else begin
			den = r;
			if (r <= b) begin
				p = fifth_power(q_div(r, b, 32));
				w = q_div(p, ONE_Q32 + p, 32);
				omw = ONE_Q32 - w;
			end else begin
				p = fifth_power(q_div(b, r, 32));
				omw = q_div(p, ONE_Q32 + p, 32);
				w = ONE_Q32 - omw;
			end
			wt = omw;
			m = q_mul(w, omw, 32);
		end
		k = q_mul(ppr, m, 32);
		f.idx = id;
		f.ax = axis_accel(k, x, den, lin_x, wt);
		f.ay = axis_accel(k, y, den, lin_y, wt);
		f.az = axis_accel(k, z, den, 0, wt);
		f.pot = sat32(q_mul(amp, q_mul(pp, wt, 32), 32));
		return f;
	endfunction

	// ---------------- bus tasks ----------------
	task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_wdata <= v;
		case (r)
			REG_SOFT_MODE:    soft_on = v[0];
			REG_FORCE_SCALE:  amp = v;
			REG_SCALE_LENGTH: b_len = v[30:0];
			REG_COS_TWO_PHI:  cos2 = v;
			REG_SIN_TWO_PHI:  sin2 = v;
			REG_CENTER_X:     cen_x = v;
			REG_CENTER_Y:     cen_y = v;
			REG_CENTER_Z:     cen_z = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic cfg_release();
		cfg_we <= 1'b0;
	endtask

	task automatic set_bar(input logic sm, input logic [31:0] a, input logic [31:0] bl,
		input logic [31:0] c, input logic [31:0] s, input logic [31:0] x0,
		input logic [31:0] y0, input logic [31:0] z0);
		write_reg(REG_SOFT_MODE, 32'(sm));
		write_reg(REG_FORCE_SCALE, a);
		write_reg(REG_SCALE_LENGTH, bl);
		write_reg(REG_COS_TWO_PHI, c);
		write_reg(REG_SIN_TWO_PHI, s);
		write_reg(REG_CENTER_X, x0);
		write_reg(REG_CENTER_Y, y0);
		write_reg(REG_CENTER_Z, z0);
		cfg_release();
	endtask

	task automatic send_particle(input logic [31:0] id, input logic lvl,
		input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pz, py, px, id};
		s_axis_tuser <= lvl;
		do @(posedge clk); while (!s_axis_tready);
		requests_sent++;
		if (lvl) force_q.push_back(bar_force(id, px, py, pz));
	endtask

	// wait for all results, then let any trailing bubbles leave the pipe
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (force_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			2: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
			default: return 32'($signed($urandom_range(0, 32'h0000_0400)) - 32'sh200);
		endcase
	endfunction

	function automatic logic [31:0] rand_trig();
		case ($urandom_range(0, 4))
			0: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
		endcase
	endfunction

	task automatic random_setting();
		logic [31:0] bl;
		bl = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(1, 32'h0008_0000);
		set_bar(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0 ? $urandom :
			32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
			bl, rand_trig(), rand_trig(),
			$urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000),
			$urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000),
			$urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000));
	endtask

	task automatic random_burst(input int n);
		repeat (n) send_particle($urandom, $urandom_range(0, 9) != 0,
			rand_coord(), rand_coord(), rand_coord());
	endtask

	// ---------------- tests ----------------
	task automatic test_directed();
		set_bar(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h4000_0000, 32'h0, 0, 0, 0);
		send_particle(32'h0, 1'b1, 0, 0, 0);                // zero radius
		send_particle(32'hFFFF_FFFF, 1'b0, 32'h0001_0000, 0, 0);  // level clear
		send_particle(32'h1, 1'b1, 32'h0001_0000, 0, 0);
		send_particle(32'h2, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_particle(32'h3, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_particle(32'hFFFF_FFFF, 1'b1, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
		drain();
		// soft profile, huge amplitude, out-of-range trig, extreme centers
		set_bar(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_particle(32'h10, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_particle(32'h11, 1'b1, 0, 0, 0);
		send_particle(32'h12, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		drain();
		// zero scale length, most negative amplitude
		set_bar(1'b0, 32'h8000_0000, 32'h0, 32'hC000_0000, 32'h4000_0000, 0, 0, 0);
		send_particle(32'h20, 1'b1, 32'h0000_0001, 32'h0, 32'h0);
		send_particle(32'h21, 1'b1, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_0100);
		send_particle(32'h22, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_particle(32'h23, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		drain();
		set_bar(1'b1, 32'h0000_0001, 32'h0000_0001, 32'h4000_0000, 32'hC000_0000,
			0, 0, 0);
		send_particle(32'h30, 1'b1, 0, 0, 32'h0000_0001);
		send_particle(32'h31, 1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0);
		drain();
	endtask

	task automatic test_random_settings();
		repeat (10) begin
			random_setting();
			random_burst(90);
			drain();
		end
	endtask

	task automatic test_backpressure();
		random_setting();
		hold_req = 1'b1;
		random_burst(350);
		drain();
	endtask

	task automatic test_pause();
		random_setting();
		random_burst(60);
		s_axis_tvalid <= 1'b0;
		while (force_q.size() != 0) @(posedge clk);
		random_burst(60);
		drain();
	endtask

	task automatic test_full_rate();
		quiet = 1'b1;
		random_setting();
		random_burst(150);
		drain();
	endtask

	// ---------------- receiver, checker, watchdog ----------------
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		force_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
				m_axis_tdata[127:96], m_axis_tdata[159:128]};
			if (force_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result idx=%h", got.idx);
			end else begin
				want = force_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp idx=%h ax=%h ay=%h az=%h pot=%h / got idx=%h ax=%h ay=%h az=%h pot=%h",
							want.idx, want.ax, want.ay, want.az, want.pot,
							got.idx, got.ax, got.ay, got.az, got.pot);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		soft_on = 1'b0;
		amp = 0;
		b_len = 31'd65536;
		cos2 = 32'h4000_0000;
		sin2 = 0;
		cen_x = 0;
		cen_y = 0;
		cen_z = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_backpressure();
		test_pause();
		test_full_rate();
		$display("Sent %0d requests over 17 register settings, checked %0d force results.",
			requests_sent, results_seen);
		$display("Covered both profiles, zero radius, clamped centers and long output stalls.");
		if (mismatches == 0 && force_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, force_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
